// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define CHK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");

// Checked only while reset is released.
`define CHK_ACTIVE(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

`endif

// ----- src/pisc_pkg.sv -----
`timescale 1ns / 1ps
package pisc_pkg;

  localparam int POS_W   = 24;
  localparam int ERR_W   = POS_W + 1;
  localparam int DIF_W   = ERR_W + 1;
  localparam int GAIN_W  = 32;
  localparam int INTEG_W = 32;
  localparam int DRV_W   = 16;
  localparam int THR_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 64;
  localparam int Y_W     = ACC_W - FRAC_W;
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + INTEG_W;
  localparam int PD_W    = GAIN_W + DIF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [GAIN_W-1:0]  RST_GAIN_P    = 32'sd2621;
  localparam logic signed [GAIN_W-1:0]  RST_GAIN_I    = 32'sd655;
  localparam logic signed [GAIN_W-1:0]  RST_GAIN_D    = 32'sd0;
  localparam logic signed [INTEG_W-1:0] RST_INTEG_UP  = 32'sd60000;
  localparam logic signed [INTEG_W-1:0] RST_INTEG_LO  = -32'sd60000;
  localparam logic signed [DRV_W-1:0]   RST_DRIVE_UP  = 16'sd500;
  localparam logic signed [DRV_W-1:0]   RST_DRIVE_LO  = -16'sd500;
  localparam logic [THR_W-1:0]          RST_SEP_THR   = 24'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_INTEG_UP = 3'd3,
    CFG_INTEG_LO = 3'd4,
    CFG_DRIVE_UP = 3'd5,
    CFG_DRIVE_LO = 3'd6,
    CFG_SEP_THR  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] measured;
    logic signed [POS_W-1:0] target;
    logic                    integrate_enable;
  } in_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic signed [INTEG_W-1:0] integral_upper;
    logic signed [INTEG_W-1:0] integral_lower;
    logic signed [DRV_W-1:0]   drive_upper;
    logic signed [DRV_W-1:0]   drive_lower;
    logic [THR_W-1:0]          separation_threshold;
  } cfg_t;

  // error-path stage payload
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIF_W-1:0]   dif;
  } integ_t;

  // product stage payload
  typedef struct packed {
    logic signed [PP_W-1:0] p_prod;
    logic signed [PI_W-1:0] i_prod;
    logic signed [PD_W-1:0] d_prod;
  } prod_t;

endpackage

// ----- src/pid_integral_separation_clamp.sv -----
`timescale 1ns / 1ps
// Each request passes the stage 0..3 registers; stage 3 drives out_data.
// Throughput: one request per cycle while out_stall is low; the integral
//   loop closes in the error stage; back-to-back requests never wait on it.
// Reset (rst_n low, synchronous): pipeline emptied, integral and previous
//   error cleared, all configuration registers back to their defaults.
module pid_integral_separation_clamp
  import pisc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Pipeline:
  //   stage 0  input register
  //   stage 1  error, clamped/separated integral, error delta (holds loop state)
  //   stage 2  the three gain products
  //   stage 3  64-bit sum, floor shift by 16, output saturation -> out_data
  // Each stage loads when it is empty or its successor takes its content,
  // so bubbles collapse and a stall at the output only backs up the chain.

  cfg_t   cfg_r;
  logic   in_valid_r;
  in_t    in_r;
  logic   rdy0, rdy1, rdy2, rdy3;
  logic   v1, v2;
  integ_t s1;
  prod_t  s2;

  // Configuration is always accepted; the contract keeps writes to idle time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p               <= RST_GAIN_P;
      cfg_r.gain_i               <= RST_GAIN_I;
      cfg_r.gain_d               <= RST_GAIN_D;
      cfg_r.integral_upper       <= RST_INTEG_UP;
      cfg_r.integral_lower       <= RST_INTEG_LO;
      cfg_r.drive_upper          <= RST_DRIVE_UP;
      cfg_r.drive_lower          <= RST_DRIVE_LO;
      cfg_r.separation_threshold <= RST_SEP_THR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:   cfg_r.gain_p               <= cfg_data;
        CFG_GAIN_I:   cfg_r.gain_i               <= cfg_data;
        CFG_GAIN_D:   cfg_r.gain_d               <= cfg_data;
        CFG_INTEG_UP: cfg_r.integral_upper       <= cfg_data;
        CFG_INTEG_LO: cfg_r.integral_lower       <= cfg_data;
        CFG_DRIVE_UP: cfg_r.drive_upper          <= cfg_data[DRV_W-1:0];
        CFG_DRIVE_LO: cfg_r.drive_lower          <= cfg_data[DRV_W-1:0];
        CFG_SEP_THR:  cfg_r.separation_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage 0: input register.
  assign rdy0     = !in_valid_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (rdy0) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      in_r <= in_data;
    end
  end

  pisc_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid_r),
    .in_ready  (rdy1),
    .in_data   (in_r),
    .out_valid (v1),
    .out_ready (rdy2),
    .out_data  (s1)
  );

  pisc_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (v1),
    .in_ready  (rdy2),
    .in_data   (s1),
    .out_valid (v2),
    .out_ready (rdy3),
    .out_data  (s2)
  );

  pisc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (v2),
    .in_ready  (rdy3),
    .in_data   (s2),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/pisc_integ.sv -----
`timescale 1ns / 1ps
module pisc_integ
  import pisc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output integ_t out_data
);

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic                      valid_r;
  integ_t                    data_r, data_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   sum;
  logic signed [INTEG_W:0]   lim_up, lim_lo;
  logic signed [INTEG_W-1:0] clamped;
  logic [ERR_W-1:0]          mag;
  logic                      sep;
  logic                      load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    err    = ERR_W'(in_data.target) - ERR_W'(in_data.measured);
    sum    = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err);
    lim_up = (INTEG_W+1)'(cfg.integral_upper);
    lim_lo = (INTEG_W+1)'(cfg.integral_lower);
    // upper first; if inverted, sum >= upper gives upper, else lower
    if (sum >= lim_up) begin
      clamped = cfg.integral_upper;
    end else if (sum <= lim_lo) begin
      clamped = cfg.integral_lower;
    end else begin
      clamped = sum[INTEG_W-1:0];
    end
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    sep = mag > {1'b0, cfg.separation_threshold};
    integ_nxt = (!in_data.integrate_enable || sep) ? '0 : clamped;
    data_nxt.err   = err;
    data_nxt.integ = integ_nxt;
    data_nxt.dif   = DIF_W'(err) - DIF_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (load) begin
        integ_r    <= integ_nxt;
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/pisc_mult.sv -----
`timescale 1ns / 1ps
module pisc_mult
  import pisc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  integ_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output prod_t  out_data
);

  logic  valid_r;
  prod_t data_r, data_nxt;
  logic  load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // three independent signed multipliers, each at most 32x32
  always_comb begin
    data_nxt.p_prod = PP_W'(cfg.gain_p) * PP_W'(in_data.err);
    data_nxt.i_prod = PI_W'(cfg.gain_i) * PI_W'(in_data.integ);
    data_nxt.d_prod = PD_W'(cfg.gain_d) * PD_W'(in_data.dif);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/pisc_out.sv -----
`timescale 1ns / 1ps
module pisc_out
  import pisc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic                    valid_r;
  out_t                    data_r, data_nxt;
  logic                    load;
  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0]   y;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    acc = ACC_W'(in_data.p_prod) + ACC_W'(in_data.i_prod) + ACC_W'(in_data.d_prod);
    // arithmetic shift gives floor rounding
    y   = Y_W'(acc >>> FRAC_W);
    if (y > Y_W'(cfg.drive_upper)) begin
      data_nxt.drive     = cfg.drive_upper;
      data_nxt.saturated = 1'b1;
    end else if (y < Y_W'(cfg.drive_lower)) begin
      data_nxt.drive     = cfg.drive_lower;
      data_nxt.saturated = 1'b1;
    end else begin
      data_nxt.drive     = y[DRV_W-1:0];
      data_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/pisc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pisc_checker
  import pisc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // pipeline comes out of reset empty
  `CHK_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)
  `CHK_ALWAYS(a_rst_accepts, !rst_n |=> !in_stall)
  // back-pressure on the request side only comes from a stalled result
  `CHK_ACTIVE(a_stall_cause, in_stall |-> (out_valid && out_stall))
  // a stalled result holds
  `CHK_ACTIVE(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

endmodule

bind pid_integral_separation_clamp pisc_checker u_pisc_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import pisc_pkg::*;

  // Pipeline depth of the block; used for settle time before config writes
  // and at the end of the run.
  localparam int LATENCY     = 4;
  localparam int SETTLE      = LATENCY + 4;
  // Cycles without any accepted request, result or config write.
  localparam int STALL_LIMIT = 1000;
  localparam int REPORT_MAX  = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pid_integral_separation_clamp DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Controller model: its own copy of the registers and loop state.
  // ---------------------------------------------------------------------
  logic signed [GAIN_W-1:0]  kp, ki, kd;
  logic signed [INTEG_W-1:0] integ_hi, integ_lo;
  logic signed [DRV_W-1:0]   drive_hi, drive_lo;
  logic [THR_W-1:0]          sep_thr;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   last_err;

  // Expected drive outputs, oldest first.
  out_t drive_q[$];

  int mismatch_count = 0;
  int in_idle_pct    = 0;   // chance per cycle that the sender idles
  int stall_pct      = 0;   // chance per cycle that the receiver stalls
  int hold_cycles    = 0;   // long receiver hold-off, counted down below

  function automatic void model_reset();
    kp        = RST_GAIN_P;
    ki        = RST_GAIN_I;
    kd        = RST_GAIN_D;
    integ_hi  = RST_INTEG_UP;
    integ_lo  = RST_INTEG_LO;
    drive_hi  = RST_DRIVE_UP;
    drive_lo  = RST_DRIVE_LO;
    sep_thr   = RST_SEP_THR;
    integ_acc = '0;
    last_err  = '0;
  endfunction

  // One control update: integrate with clamp, separation, PID sum in
  // Q48.16 floored to an integer, then output saturation.
  function automatic out_t pid_update(in_t req);
    longint err, mag, sum, dif, acc, y;
    out_t   res;
    err = longint'($signed(req.target)) - longint'($signed(req.measured));
    mag = (err < 0) ? -err : err;
    if (req.integrate_enable) begin
      sum = longint'(integ_acc) + err;
      // upper limit checked first; decides when the limits are inverted
      if (sum >= longint'(integ_hi)) sum = longint'(integ_hi);
      else if (sum <= longint'(integ_lo)) sum = longint'(integ_lo);
      integ_acc = sum[INTEG_W-1:0];
    end else begin
      integ_acc = '0;
    end
    // separation: only a magnitude strictly above the threshold clears
    if (mag > longint'(sep_thr)) integ_acc = '0;
    dif = err - longint'(last_err);
    acc = longint'(kp) * err + longint'(ki) * longint'(integ_acc)
        + longint'(kd) * dif;
    y = acc >>> FRAC_W;   // arithmetic shift gives floor rounding
    last_err = err[ERR_W-1:0];
    res.saturated = 1'b0;
    if (y > longint'(drive_hi)) begin
      y = longint'(drive_hi);
      res.saturated = 1'b1;
    end else if (y < longint'(drive_lo)) begin
      y = longint'(drive_lo);
      res.saturated = 1'b1;
    end
    res.drive = y[DRV_W-1:0];
    return res;
  endfunction

  function automatic in_t mk_req(int meas, int tgt, bit en);
    in_t r;
    r.measured         = meas[POS_W-1:0];
    r.target           = tgt[POS_W-1:0];
    r.integrate_enable = en;
    return r;
  endfunction

  // Mostly plausible tracking samples (small error, integrator on) so the
  // integral builds up and hits its clamps; the rest is full-range noise.
  function automatic in_t random_request();
    int  meas, delta;
    in_t r;
    if ($urandom_range(99) < 75) begin
      meas  = $urandom_range(0, 200000) - 100000;
      delta = $urandom_range(0, 6000) - 3000;
      r     = mk_req(meas, meas + delta, $urandom_range(9) != 0);
    end else begin
      r.measured         = POS_W'($urandom);
      r.target           = POS_W'($urandom);
      r.integrate_enable = 1'($urandom_range(1));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, receiver stall and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: a pending hold-off wins over the random stall pattern.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready) || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: drive=%0d saturated=%0b",
                   out_data.drive, out_data.saturated);
      end else begin
        want = drive_q.pop_front();
        if (want.drive !== out_data.drive ||
            want.saturated !== out_data.saturated) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch at %0t: drive exp %0d got %0d, saturated exp %0b got %0b",
                     $realtime, want.drive, out_data.drive,
                     want.saturated, out_data.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request and config drivers. All tasks start and end on a clock edge.
  // ---------------------------------------------------------------------

  // Send one request. valid stays high after acceptance so back-to-back
  // requests never drop it; a random idle gap lowers it first.
  task automatic send_req(in_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    drive_q.push_back(pid_update(req));
  endtask

  // Stop sending and wait until all results are back, plus pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Config write; only called while the pipeline is empty. Valid is lowered
  // after each write so consecutive writes see it drop in between.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P:   kp       = val;
      CFG_GAIN_I:   ki       = val;
      CFG_GAIN_D:   kd       = val;
      CFG_INTEG_UP: integ_hi = val;
      CFG_INTEG_LO: integ_lo = val;
      CFG_DRIVE_UP: drive_hi = val[DRV_W-1:0];
      CFG_DRIVE_LO: drive_lo = val[DRV_W-1:0];
      CFG_SEP_THR:  sep_thr  = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int gp, int gi, int gd, int ihi, int ilo,
                           int dhi, int dlo, int thr);
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_INTEG_UP, ihi);
    write_reg(CFG_INTEG_LO, ilo);
    write_reg(CFG_DRIVE_UP, dhi);
    write_reg(CFG_DRIVE_LO, dlo);
    write_reg(CFG_SEP_THR, thr);
  endtask

  // Random settings: usually a sane tuning, sometimes anything at all
  // (inverted limits and huge gains included).
  task automatic random_settings();
    int g[3];
    if ($urandom_range(3) != 0) begin
      foreach (g[i]) begin
        g[i] = $urandom_range(0, 1 << 18);
        if ($urandom_range(1)) g[i] = -g[i];
      end
      write_all(g[0], g[1], g[2],
                $urandom_range(1, 200000), -$urandom_range(1, 200000),
                $urandom_range(1, 32767), -$urandom_range(1, 32768),
                $urandom_range(0, 20000));
    end else begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset values: separation boundary, integrator off, extreme positions,
  // floor rounding of a small negative error.
  task automatic test_defaults();
    send_req(mk_req(0, 0, 1'b1));
    send_req(mk_req(1000, 2500, 1'b1));       // |e| at threshold: kept
    send_req(mk_req(1000, 2501, 1'b1));       // just above: cleared
    send_req(mk_req(0, -1500, 1'b1));
    send_req(mk_req(0, 700, 1'b0));           // integrator off
    send_req(mk_req(8388607, -8388608, 1'b1));
    send_req(mk_req(-8388608, 8388607, 1'b1));
    send_req(mk_req(0, -1, 1'b1));
    drain();
  endtask

  // Unity P gain: output equal to a limit passes unflagged, one past it
  // saturates; then inverted and full-scale output limits.
  task automatic test_output_limits();
    write_all(32'sh0001_0000, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000,
              500, -500, 24'hff_ffff);
    send_req(mk_req(0, 500, 1'b1));
    send_req(mk_req(0, 501, 1'b1));
    send_req(mk_req(0, -500, 1'b1));
    send_req(mk_req(0, -501, 1'b1));
    drain();
    write_reg(CFG_DRIVE_UP, -10);
    write_reg(CFG_DRIVE_LO, 10);
    send_req(mk_req(0, 0, 1'b0));             // upper test wins
    drain();
    write_reg(CFG_DRIVE_UP, 32767);
    write_reg(CFG_DRIVE_LO, -32768);
    send_req(mk_req(0, 40000, 1'b1));
    send_req(mk_req(40000, 0, 1'b1));
    drain();
  endtask

  // Unity I gain only: accumulate into the clamps, including inverted ones.
  task automatic test_integral_clamp();
    write_all(0, 32'sh0001_0000, 0, 100, -100, 32767, -32768, 24'hff_ffff);
    send_req(mk_req(0, 60, 1'b1));
    send_req(mk_req(0, 40, 1'b1));            // sum equal to upper
    send_req(mk_req(0, 50, 1'b1));
    send_req(mk_req(300, 0, 1'b1));
    drain();
    write_reg(CFG_INTEG_UP, -50);
    write_reg(CFG_INTEG_LO, 50);
    send_req(mk_req(0, 0, 1'b1));
    send_req(mk_req(0, 10, 1'b1));
    drain();
  endtask

  // Derivative path, zero separation threshold, and full-scale gains.
  task automatic test_gains();
    write_all(0, 32'sh0001_0000, 32'sh0001_0000, 100000, -100000,
              32767, -32768, 0);
    send_req(mk_req(0, 300, 1'b1));
    send_req(mk_req(0, -200, 1'b1));
    drain();
    write_all(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh8000_0000, 32767, -32768, 24'hff_ffff);
    send_req(mk_req(-8388608, 8388607, 1'b1));
    send_req(mk_req(8388607, -8388608, 1'b1));
    drain();
  endtask

  // Receiver holds off long enough to fill the pipeline while the sender
  // keeps offering requests; then the sender waits for everything.
  task automatic test_backpressure();
    in_idle_pct = 0;
    stall_pct   = 0;
    hold_cycles = 150;
    repeat (40) send_req(random_request());
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_chance);
    in_idle_pct = idle_pct;
    stall_pct   = stall_chance;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        drain();
        random_settings();
      end
      send_req(random_request());
    end
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_output_limits();
    test_integral_clamp();
    test_gains();
    test_backpressure();
    test_random(150, 0, 0);
    test_random(150, 83, 0);
    test_random(150, 0, 83);
    test_random(150, 10, 10);

    repeat (SETTLE) @(posedge clk);
    if (drive_q.size() != 0) begin
      mismatch_count += drive_q.size();
      $display("%0d expected results never arrived", drive_q.size());
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/pisc_pkg.sv
src/pisc_integ.sv
src/pisc_mult.sv
src/pisc_out.sv
src/pid_integral_separation_clamp.sv
src/pisc_checker.sv
tb/testbench.sv
